[rtl/core/assert_macros.svh]
// Assertion macros used by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is asserted.
`define PLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Checked property, evaluated at every edge including reset.
`define PLE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`else

`define PLE_ASSERT(lbl, clk, rstn, prop)
`define PLE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/core/ple_pkg.sv]
// Shared types and constants of the positional list engine.
`default_nettype none

package ple_pkg;

  // Number of cells in the list.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_TRAV_FWD  = 3'd6,
    REQ_TRAV_BWD  = 3'd7
  } req_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wdata;
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/core/ple_if.sv]
// Request and result channel interfaces of the positional list engine.
`default_nettype none

interface ple_in_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::REQ_W-1:0]         req_type;
  logic [ple_pkg::CNT_W-1:0]         position;
  logic signed [ple_pkg::DATA_W-1:0] value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink (input valid, input req_type, input position, input value,
                output ready);
endinterface

interface ple_out_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::STAT_W-1:0]        status;
  logic signed [ple_pkg::DATA_W-1:0] item_value;
  logic                              last_of_run;
  logic [ple_pkg::CNT_W-1:0]         entry_count;

  modport source (output valid, output status, output item_value,
                  output last_of_run, output entry_count, input ready);
  modport sink (input valid, input status, input item_value,
                input last_of_run, input entry_count, output ready);
endinterface

`default_nettype wire

[rtl/core/ple_cell.sv]
// One storage cell of the list chain, shifting with its neighbors.
`default_nettype none

module ple_cell (
  input  wire logic                        clk,
  input  wire ple_pkg::cell_cmd_t          cmd,
  input  wire logic [ple_pkg::IDX_W-1:0]   my_idx,
  input  wire logic [ple_pkg::DATA_W-1:0]  left_val,
  input  wire logic [ple_pkg::DATA_W-1:0]  right_val,
  output logic      [ple_pkg::DATA_W-1:0]  val_r
);

  logic                        upd;
  logic [ple_pkg::DATA_W-1:0]  val_nxt;

  // Cells at or after the target slot move: toward the back on an insert,
  // toward the front on a delete. On an insert the target slot takes the new word.
  always_comb begin
    upd = (cmd.ins || cmd.del) && (my_idx >= cmd.idx);
    if (cmd.ins) begin
      val_nxt = (my_idx == cmd.idx) ? cmd.wdata : left_val;
    end else begin
      val_nxt = right_val;
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk) begin
    if (upd) begin
      val_r <= val_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ple_ctrl.sv]
// Request decode, occupancy count, traversal walker and result register.
`default_nettype none
`include "assert_macros.svh"

module ple_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  ple_in_if.sink    in_req,
  ple_out_if.source out_res,
  input  wire logic [ple_pkg::CAPACITY-1:0][ple_pkg::DATA_W-1:0] cell_vals,
  output ple_pkg::cell_cmd_t cmd
);

  localparam int CW = ple_pkg::CNT_W;
  localparam int IW = ple_pkg::IDX_W;
  localparam int DW = ple_pkg::DATA_W;

  // Control state.
  logic [CW-1:0] occ_r, occ_nxt;
  logic          trav_r, trav_nxt;
  logic          bwd_r, bwd_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;

  // Result register.
  logic                    ov_r, ov_nxt;
  ple_pkg::status_t        st_r, st_nxt;
  logic [DW-1:0]           val_r, val_nxt;
  logic                    last_r, last_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;

  // Decode signals.
  ple_pkg::req_t    req;
  logic             out_free;
  logic             accept;
  logic             full;
  logic             empty;
  logic             ins_bad;
  logic             del_bad;
  logic [CW-1:0]    pos_m1;
  logic [CW-1:0]    occ_m1;
  logic [IW-1:0]    ins_idx;
  logic [IW-1:0]    del_idx;
  logic [IW-1:0]    rd_idx;
  logic [DW-1:0]    rd_val;
  logic             trav_last;
  logic             ins_ok;

  assign out_free = !ov_r || out_res.ready;
  assign in_req.ready = !trav_r && out_free;
  assign accept = in_req.valid && in_req.ready;
  assign req = ple_pkg::req_t'(in_req.req_type);

  // Range checks against the current occupancy.
  always_comb begin
    full    = occ_r >= CW'(ple_pkg::CAPACITY);
    empty   = occ_r == '0;
    pos_m1  = in_req.position - CW'(1);
    occ_m1  = occ_r - CW'(1);
    ins_bad = (in_req.position == '0) ||
              ({1'b0, in_req.position} > ({1'b0, occ_r} + (CW+1)'(1)));
    del_bad = (in_req.position == '0) || (in_req.position > occ_r);
  end

  // Target slot of the request.
  always_comb begin
    case (req)
      ple_pkg::REQ_INS_FRONT: ins_idx = '0;
      ple_pkg::REQ_INS_BACK:  ins_idx = occ_r[IW-1:0];
      default:                ins_idx = pos_m1[IW-1:0];
    endcase
    case (req)
      ple_pkg::REQ_DEL_FRONT: del_idx = '0;
      ple_pkg::REQ_DEL_BACK:  del_idx = occ_m1[IW-1:0];
      default:                del_idx = pos_m1[IW-1:0];
    endcase
  end

  // Single read port over the cells: the walker while traversing,
  // otherwise the slot a delete removes.
  assign rd_idx = trav_r ? ptr_r : del_idx;
  assign rd_val = cell_vals[rd_idx];
  assign trav_last = bwd_r ? (ptr_r == '0) : (CW'(ptr_r) == occ_m1);
  assign ins_ok = !full && !((req == ple_pkg::REQ_INS_AT) && ins_bad);

  // Next state and result.
  always_comb begin
    occ_nxt  = occ_r;
    trav_nxt = trav_r;
    bwd_nxt  = bwd_r;
    ptr_nxt  = ptr_r;
    ov_nxt   = ov_r && !out_res.ready;
    st_nxt   = st_r;
    val_nxt  = val_r;
    last_nxt = last_r;
    cnt_nxt  = cnt_r;
    cmd      = '0;
    cmd.wdata = in_req.value;

    if (trav_r && out_free) begin
      // Walk one entry per cycle while the result register is free.
      ov_nxt   = 1'b1;
      st_nxt   = ple_pkg::ST_OK;
      val_nxt  = rd_val;
      last_nxt = trav_last;
      cnt_nxt  = occ_r;
      if (trav_last) begin
        trav_nxt = 1'b0;
      end else if (bwd_r) begin
        ptr_nxt = ptr_r - IW'(1);
      end else begin
        ptr_nxt = ptr_r + IW'(1);
      end
    end else if (accept) begin
      last_nxt = 1'b1;
      unique case (req)
        ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_BACK, ple_pkg::REQ_INS_AT: begin
          ov_nxt  = 1'b1;
          val_nxt = in_req.value;
          if (full) begin
            st_nxt  = ple_pkg::ST_FULL;
            cnt_nxt = occ_r;
          end else if (!ins_ok) begin
            st_nxt  = ple_pkg::ST_BADPOS;
            cnt_nxt = occ_r;
          end else begin
            st_nxt  = ple_pkg::ST_OK;
            occ_nxt = occ_r + CW'(1);
            cnt_nxt = occ_r + CW'(1);
            cmd.ins = 1'b1;
            cmd.idx = ins_idx;
          end
        end
        ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_BACK, ple_pkg::REQ_DEL_AT: begin
          ov_nxt  = 1'b1;
          val_nxt = '0;
          cnt_nxt = occ_r;
          if (empty) begin
            st_nxt = ple_pkg::ST_EMPTY;
          end else if ((req == ple_pkg::REQ_DEL_AT) && del_bad) begin
            st_nxt = ple_pkg::ST_BADPOS;
          end else begin
            st_nxt  = ple_pkg::ST_OK;
            val_nxt = rd_val;
            occ_nxt = occ_m1;
            cnt_nxt = occ_m1;
            cmd.del = 1'b1;
            cmd.idx = del_idx;
          end
        end
        ple_pkg::REQ_TRAV_FWD, ple_pkg::REQ_TRAV_BWD: begin
          if (empty) begin
            ov_nxt  = 1'b1;
            st_nxt  = ple_pkg::ST_EMPTY;
            val_nxt = '0;
            cnt_nxt = occ_r;
          end else begin
            trav_nxt = 1'b1;
            bwd_nxt  = (req == ple_pkg::REQ_TRAV_BWD);
            ptr_nxt  = (req == ple_pkg::REQ_TRAV_BWD) ? occ_m1[IW-1:0] : '0;
          end
        end
        default: begin
          ov_nxt = ov_r && !out_res.ready;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      trav_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      trav_r <= trav_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    bwd_r  <= bwd_nxt;
    ptr_r  <= ptr_nxt;
    st_r   <= st_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign out_res.valid       = ov_r;
  assign out_res.status      = st_r;
  assign out_res.item_value  = val_r;
  assign out_res.last_of_run = last_r;
  assign out_res.entry_count = cnt_r;

  // Occupancy never passes the cell count.
  `PLE_ASSERT(a_occ_bound, clk, rst_n, occ_r <= CW'(ple_pkg::CAPACITY))
  // A traversal only runs over a non-empty list.
  `PLE_ASSERT(a_trav_nonempty, clk, rst_n, !trav_r || (occ_r != '0))
  // The walker stays inside the occupied cells.
  `PLE_ASSERT(a_ptr_range, clk, rst_n, !trav_r || (CW'(ptr_r) < occ_r))
  // The list does not change while a traversal runs.
  `PLE_ASSERT(a_trav_stable, clk, rst_n, trav_r |=> (occ_r == $past(occ_r)))
  // A successful insert grows the list by one.
  `PLE_ASSERT(a_ins_grow, clk, rst_n, cmd.ins |=> (occ_r == $past(occ_r) + CW'(1)))

endmodule

`default_nettype wire

[rtl/core/positional_list_engine.sv]
// Top level of the positional list engine: a shifting chain of cells.
//
//   Channel   Direction  Contents
//   in_req    sink       req_type, position, value
//   out_res   source     status, item_value, last_of_run, entry_count
//
// On an insert or a delete the whole chain shifts in the cycle the request is accepted.
// A traversal first sets up the walker and then delivers one entry per cycle while
// results are taken, as entries leave through the single read port over the cells.
// Reset clears the occupancy count, the traversal flag and the result valid flag;
// cell contents and the result payload are left as they are.
// A stalled result holds in the result register; new requests are refused
// while a traversal runs or while a result waits and is not taken.
`default_nettype none

module positional_list_engine (
  input  wire logic clk,
  input  wire logic rst_n,
  ple_in_if.sink    in_req,
  ple_out_if.source out_res
);

  localparam int N  = ple_pkg::CAPACITY;
  localparam int IW = ple_pkg::IDX_W;
  localparam int DW = ple_pkg::DATA_W;

  ple_pkg::cell_cmd_t          cmd;
  logic [N-1:0][DW-1:0]        cell_vals;

  // Request decode, counting and result path.
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cell_vals (cell_vals),
    .cmd       (cmd)
  );

  // Row of cells, each wired to its two neighbors.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [DW-1:0] left_val;
    logic [DW-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_vals[g-1];
    end

    if (g == N-1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_vals[g+1];
    end

    ple_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .my_idx    (IW'(g)),
      .left_val  (left_val),
      .right_val (right_val),
      .val_r     (cell_vals[g])
    );
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the positional list engine: directed and random requests.
import ple_pkg::*;

// One expected or observed result.
typedef struct {
  status_t                  status;
  logic signed [DATA_W-1:0] item_value;
  logic                     last_of_run;
  logic [CNT_W-1:0]         entry_count;
} list_result_t;

// Mirrors the list contents and keeps the results that are still owed.
class list_scoreboard;
  logic signed [DATA_W-1:0] cells[$];
  list_result_t             owed[$];
  int mismatches;
  int requests;
  int results;
  int n_full;
  int n_badpos;
  int n_empty;
  int n_trav;
  int peak;

  function void owe(status_t st, logic signed [DATA_W-1:0] v, logic last);
    list_result_t r;
    r.status      = st;
    r.item_value  = v;
    r.last_of_run = last;
    r.entry_count = CNT_W'(cells.size());
    owed.push_back(r);
    if (st == ST_FULL) n_full++;
    if (st == ST_BADPOS) n_badpos++;
    if (st == ST_EMPTY) n_empty++;
  endfunction

  // Applies an accepted request to the mirror and queues what it must produce.
  function void note_request(req_t op, logic [CNT_W-1:0] pos,
                             logic signed [DATA_W-1:0] val);
    int fill;
    int slot;
    logic signed [DATA_W-1:0] taken;
    fill = cells.size();
    requests++;
    case (op)
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
        if (fill >= CAPACITY) begin
          owe(ST_FULL, val, 1'b1);
        end else if (op == REQ_INS_AT && (pos < 1 || pos > fill + 1)) begin
          owe(ST_BADPOS, val, 1'b1);
        end else begin
          slot = (op == REQ_INS_FRONT) ? 0 : (op == REQ_INS_BACK) ? fill : pos - 1;
          cells.insert(slot, val);
          owe(ST_OK, val, 1'b1);
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
        if (fill == 0) begin
          owe(ST_EMPTY, '0, 1'b1);
        end else if (op == REQ_DEL_AT && (pos < 1 || pos > fill)) begin
          owe(ST_BADPOS, '0, 1'b1);
        end else begin
          slot = (op == REQ_DEL_FRONT) ? 0 : (op == REQ_DEL_BACK) ? fill - 1 : pos - 1;
          taken = cells[slot];
          cells.delete(slot);
          owe(ST_OK, taken, 1'b1);
        end
      end
      default: begin
        n_trav++;
        if (fill == 0) begin
          owe(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++) begin
            slot = (op == REQ_TRAV_FWD) ? i : fill - 1 - i;
            owe(ST_OK, cells[slot], i == fill - 1);
          end
        end
      end
    endcase
    if (cells.size() > peak) peak = cells.size();
  endfunction

  // Compares a delivered result with the oldest one owed.
  function void check_result(list_result_t got);
    list_result_t want;
    results++;
    if (owed.size() == 0) begin
      $display("%0t: unexpected result, none owed; actual st=%0d val=%0d last=%0b cnt=%0d",
               $time, got.status, got.item_value, got.last_of_run, got.entry_count);
      mismatches++;
      return;
    end
    want = owed.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: result status mismatch, expected %0d actual %0d",
               $time, want.status, got.status);
      mismatches++;
    end
    if (got.item_value !== want.item_value) begin
      $display("%0t: item_value mismatch, expected %0d actual %0d",
               $time, want.item_value, got.item_value);
      mismatches++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $display("%0t: last_of_run mismatch, expected %0b actual %0b",
               $time, want.last_of_run, got.last_of_run);
      mismatches++;
    end
    if (got.entry_count !== want.entry_count) begin
      $display("%0t: entry_count mismatch, expected %0d actual %0d",
               $time, want.entry_count, got.entry_count);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;
  int   cycles;
  bit   calm;
  bit   hold_request;
  int   hold_left;

  list_scoreboard book;

  ple_in_if  in_req();
  ple_out_if out_res();

  positional_list_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res)
  );

  // Clock with a period of 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d results still owed.",
               CYCLE_LIMIT, book.owed.size());
      $display("status: fail");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge; results are checked first.
  always @(posedge clk) begin
    list_result_t got;
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        got.status      = status_t'(out_res.status);
        got.item_value  = out_res.item_value;
        got.last_of_run = out_res.last_of_run;
        got.entry_count = out_res.entry_count;
        book.check_result(got);
      end
      if (in_req.valid && in_req.ready)
        book.note_request(req_t'(in_req.req_type), in_req.position, in_req.value);
    end
  end

  // Result side: random stalls, one long hold-off on demand, none while calm.
  initial begin
    out_res.ready = 1'b0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // Offers one request, after a random gap unless calm, and waits until it is taken.
  task automatic send_request(req_t op, logic [CNT_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        @(negedge clk);
        in_req.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_req.valid    <= 1'b1;
    in_req.req_type <= op;
    in_req.position <= pos;
    in_req.value    <= val;
    do @(posedge clk); while (!in_req.ready);
  endtask

  // Random requests in alternating fill and drain phases, mostly well placed.
  task automatic run_random(int count);
    int fill;
    int pick;
    bit grow;
    req_t op;
    logic [CNT_W-1:0] pos;
    logic signed [DATA_W-1:0] val;
    for (int k = 0; k < count; k++) begin
      calm = (k >= 100 && k < 130);
      if (k == 70) hold_request = 1'b1;
      grow = ((k / 30) % 2) == 0;
      fill = book.cells.size();
      pick = $urandom_range(99);
      if (pick < 10)
        op = $urandom_range(1) ? REQ_TRAV_FWD : REQ_TRAV_BWD;
      else if (pick < (grow ? 82 : 28))
        op = req_t'(3'($urandom_range(2)));
      else
        op = req_t'(3'($urandom_range(5, 3)));
      if ($urandom_range(99) < 15)
        pos = CNT_W'($urandom_range(127));
      else if (op == REQ_DEL_AT)
        pos = CNT_W'($urandom_range(fill > 0 ? fill : 1, 1));
      else
        pos = CNT_W'($urandom_range(fill + 1, 1));
      pick = $urandom_range(99);
      if (pick < 6)
        val = 32'sh8000_0000;
      else if (pick < 12)
        val = 32'sh7fff_ffff;
      else
        val = $urandom;
      send_request(op, pos, val);
    end
    calm = 1'b0;
  endtask

  // Reset, directed corner cases, random traffic, then drain and report.
  initial begin
    book = new();
    cycles = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_req.valid    = 1'b0;
    in_req.req_type = REQ_INS_FRONT;
    in_req.position = '0;
    in_req.value    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: traversals and every delete report empty.
    send_request(REQ_TRAV_FWD, 0, 0);
    send_request(REQ_TRAV_BWD, 0, 0);
    send_request(REQ_DEL_FRONT, 0, 0);
    send_request(REQ_DEL_BACK, 0, 0);
    send_request(REQ_DEL_AT, 1, 0);
    // Positional insert into an empty list: only position one is valid.
    send_request(REQ_INS_AT, 0, 32'sd5);
    send_request(REQ_INS_AT, 2, 32'sd6);
    send_request(REQ_INS_AT, 1, 32'sh8000_0000);
    // Extreme values at both ends and in the middle.
    send_request(REQ_INS_FRONT, 0, 32'sh7fff_ffff);
    send_request(REQ_INS_BACK, 127, 32'sd0);
    send_request(REQ_INS_BACK, 0, -32'sd1);
    send_request(REQ_INS_AT, 3, 32'sh5555_aaaa);
    send_request(REQ_INS_AT, 6, 32'sh1234_5678);
    send_request(REQ_INS_AT, 7, 32'sd9);
    send_request(REQ_INS_AT, 127, 32'sd10);
    // Bad delete positions (0, 127) leave the list alone; position 7 removes the last entry.
    send_request(REQ_DEL_AT, 0, 0);
    send_request(REQ_DEL_AT, 7, 0);
    send_request(REQ_DEL_AT, 127, 0);
    send_request(REQ_TRAV_FWD, 0, 0);
    send_request(REQ_TRAV_BWD, 0, 0);
    send_request(REQ_DEL_AT, 2, 0);
    send_request(REQ_DEL_FRONT, 0, 0);
    send_request(REQ_DEL_BACK, 0, 0);
    send_request(REQ_DEL_AT, 3, 0);

    run_random(126);

    @(negedge clk);
    in_req.valid <= 1'b0;
    while (book.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d results from %0d requests; peak fill %0d of %0d, %0d traversals.",
             book.results, book.requests, book.peak, CAPACITY, book.n_trav);
    $display("Rejections seen: %0d full, %0d bad position, %0d empty.",
             book.n_full, book.n_badpos, book.n_empty);
    if (book.mismatches == 0 && book.owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[positional_list_engine.f]
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_if.sv
rtl/core/ple_cell.sv
rtl/core/ple_ctrl.sv
rtl/core/positional_list_engine.sv
bench/tb_top.sv
